// ===== design/welm_pkg.sv =====
// Shared types, sizes and helpers for the windowed event label matcher.
// No dependencies; used by welm_core and the top level.
package welm_pkg;

  // Sizes
  localparam int MAX_EVENTS = 1024;
  localparam int MAX_LABEL  = 63;
  localparam int SIDE       = MAX_LABEL + 1;
  localparam int LIST_DEPTH = MAX_EVENTS;
  localparam int CELL_DEPTH = SIDE * SIDE;
  localparam int LIST_AW    = $clog2(LIST_DEPTH);
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int CNT_W      = LIST_AW + 1;
  localparam int SWEEP_N    = (CELL_DEPTH > LIST_DEPTH) ? CELL_DEPTH : LIST_DEPTH;
  localparam int SWEEP_AW   = $clog2(SWEEP_N);

  // Field widths
  localparam int TIME_W   = 32;
  localparam int LABEL_W  = 6;
  localparam int WIN_W    = 16;
  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int EVT_W    = TIME_W + LABEL_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_ONE = 2'd0,
    MODE_LOAD_TWO = 2'd1,
    MODE_COMPUTE  = 2'd2,
    MODE_READ     = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_e;

  // Request into the core, captured on the accepted beat
  typedef struct packed {
    mode_e              mode;
    logic [TIME_W-1:0]  event_time;
    logic [LABEL_W-1:0] event_label;
    logic [LABEL_W-1:0] cell_row;
    logic [LABEL_W-1:0] cell_col;
  } req_t;

  // Response from the core
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LABEL_W-1:0] max_label_one;
    logic [LABEL_W-1:0] max_label_two;
    status_e            status;
  } rsp_t;

  function automatic logic [VALUE_W-1:0] sat_inc(logic [VALUE_W-1:0] v);
    return (v == '1) ? v : v + VALUE_W'(1);
  endfunction

  function automatic logic [CELL_AW-1:0] cell_idx(logic [LABEL_W-1:0] r,
                                                   logic [LABEL_W-1:0] c);
    return CELL_AW'(CELL_AW'(r) * CELL_AW'(SIDE) + CELL_AW'(c));
  endfunction

  function automatic logic [LABEL_W-1:0] clamp_label(logic [LABEL_W-1:0] l);
    return (int'(l) > MAX_LABEL) ? LABEL_W'(MAX_LABEL) : l;
  endfunction

endpackage

// ===== design/welm_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module welm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/welm_core.sv =====
// Sequencer and storage of the matcher: event lists, consumed flags, pair counts
// and confusion cells in welm_ram instances. Depends on welm_pkg, welm_ram.
module welm_core import welm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIN_W-1:0] win_i,
  input  logic             start_i,
  input  req_t             req_i,
  output logic             ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ack_i,
  output rsp_t             rsp_o
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_CELL   = 18'b000000000000000010,
    S_RESP   = 18'b000000000000000100,
    S_CLEAR  = 18'b000000000000001000,
    S_I_RD   = 18'b000000000000010000,
    S_I_CHK  = 18'b000000000000100000,
    S_J_RD   = 18'b000000000001000000,
    S_J_CHK  = 18'b000000000010000000,
    S_K_RD   = 18'b000000000100000000,
    S_K_CHK  = 18'b000000001000000000,
    S_PC_WR  = 18'b000000010000000000,
    S_END_I  = 18'b000000100000000000,
    S_M_WR   = 18'b000001000000000000,
    S_U1_RD  = 18'b000010000000000000,
    S_U1_CHK = 18'b000100000000000000,
    S_U2_RD  = 18'b001000000000000000,
    S_U2_CHK = 18'b010000000000000000,
    S_U_WR   = 18'b100000000000000000
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic [CNT_W-1:0]   count1_q, count1_d, count2_q, count2_d;
  logic [LABEL_W-1:0] k1_q, k1_d, k2_q, k2_d, matk1_q, matk1_d, matk2_q, matk2_d;
  logic               computed_q, computed_d;

  // Working registers
  logic               pass_q, pass_d, scan_two_q, scan_two_d, found_q, found_d;
  logic [SWEEP_AW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [TIME_W-1:0]  t_q, t_d;
  logic [LABEL_W-1:0] l1_q, l1_d, l2_q, l2_d, bl2_q, bl2_d;
  logic [VALUE_W-1:0] best_q, best_d, total_q, total_d, value_q, value_d;
  logic [LIST_AW-1:0] bj_q, bj_d;
  logic [CELL_AW-1:0] idx_q, idx_d;
  status_e            status_q, status_d;

  // Memory ports
  logic               r1_we, r2_we, c1_we, c2_we, c1_wd, c2_wd, pc_we, cm_we;
  logic [LIST_AW-1:0] r1_wa, r2_wa, c1_wa, c2_wa, r2_ra;
  logic [EVT_W-1:0]   r1_wd, r2_wd, r1_rd, r2_rd;
  logic               c1_rd, c2_rd;
  logic [CELL_AW-1:0] pc_wa, pc_ra, cm_wa, cm_ra;
  logic [VALUE_W-1:0] pc_wd, cm_wd, pc_rd, cm_rd;

  logic [LABEL_W-1:0] lab_in, r1_lab, r2_lab;
  logic [TIME_W-1:0]  r1_time, r2_time;
  logic [TIME_W:0]    w_ext;
  logic               j_before, k_inside;
  logic [VALUE_W-1:0] pc_inc, cm_inc;

  assign lab_in  = clamp_label(req_i.event_label);
  assign r1_lab  = r1_rd[TIME_W +: LABEL_W];
  assign r1_time = r1_rd[TIME_W-1:0];
  assign r2_lab  = r2_rd[TIME_W +: LABEL_W];
  assign r2_time = r2_rd[TIME_W-1:0];
  assign w_ext   = {{(TIME_W + 1 - WIN_W){1'b0}}, win_i};
  assign pc_inc  = sat_inc(pc_rd);
  assign cm_inc  = sat_inc(cm_rd);

  // Window tests; a consumed list-two event acts as time -1
  assign j_before = c2_rd ? (t_q >= TIME_W'(win_i))
                          : (({1'b0, r2_time} + w_ext) < {1'b0, t_q});
  assign k_inside = c2_rd | ({1'b0, r2_time} <= ({1'b0, t_q} + w_ext));

  // Storage
  welm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(EVT_W)) u_list_one (
    .clk_i, .we_i(r1_we), .waddr_i(r1_wa), .wdata_i(r1_wd),
    .raddr_i(i_q[LIST_AW-1:0]), .rdata_o(r1_rd));
  welm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(EVT_W)) u_list_two (
    .clk_i, .we_i(r2_we), .waddr_i(r2_wa), .wdata_i(r2_wd),
    .raddr_i(r2_ra), .rdata_o(r2_rd));
  welm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(1)) u_used_one (
    .clk_i, .we_i(c1_we), .waddr_i(c1_wa), .wdata_i(c1_wd),
    .raddr_i(i_q[LIST_AW-1:0]), .rdata_o(c1_rd));
  welm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(1)) u_used_two (
    .clk_i, .we_i(c2_we), .waddr_i(c2_wa), .wdata_i(c2_wd),
    .raddr_i(r2_ra), .rdata_o(c2_rd));
  welm_ram #(.DEPTH(CELL_DEPTH), .WIDTH(VALUE_W)) u_pair_cnt (
    .clk_i, .we_i(pc_we), .waddr_i(pc_wa), .wdata_i(pc_wd),
    .raddr_i(pc_ra), .rdata_o(pc_rd));
  welm_ram #(.DEPTH(CELL_DEPTH), .WIDTH(VALUE_W)) u_conf_cells (
    .clk_i, .we_i(cm_we), .waddr_i(cm_wa), .wdata_i(cm_wd),
    .raddr_i(cm_ra), .rdata_o(cm_rd));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count1_d   = count1_q;
    count2_d   = count2_q;
    k1_d       = k1_q;
    k2_d       = k2_q;
    matk1_d    = matk1_q;
    matk2_d    = matk2_q;
    computed_d = computed_q;
    pass_d     = pass_q;
    scan_two_d = scan_two_q;
    found_d    = found_q;
    clr_d      = clr_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    t_d        = t_q;
    l1_d       = l1_q;
    l2_d       = l2_q;
    bl2_d      = bl2_q;
    best_d     = best_q;
    total_d    = total_q;
    value_d    = value_q;
    bj_d       = bj_q;
    idx_d      = idx_q;
    status_d   = status_q;

    r1_we = 1'b0;
    r1_wa = count1_q[LIST_AW-1:0];
    r1_wd = {lab_in, req_i.event_time};
    r2_we = 1'b0;
    r2_wa = count2_q[LIST_AW-1:0];
    r2_wd = {lab_in, req_i.event_time};
    c1_we = 1'b0;
    c1_wa = clr_q[LIST_AW-1:0];
    c1_wd = 1'b0;
    c2_we = 1'b0;
    c2_wa = clr_q[LIST_AW-1:0];
    c2_wd = 1'b0;
    pc_we = 1'b0;
    pc_wa = clr_q[CELL_AW-1:0];
    pc_wd = '0;
    pc_ra = cell_idx(l1_q, r2_lab);
    cm_we = 1'b0;
    cm_wa = clr_q[CELL_AW-1:0];
    cm_wd = '0;
    cm_ra = idx_q;
    r2_ra = (state_q == S_J_RD || state_q == S_U2_RD) ? j_q[LIST_AW-1:0]
                                                      : k_q[LIST_AW-1:0];

    case (state_q)
      S_IDLE: begin
        cm_ra = cell_idx(req_i.cell_row, req_i.cell_col);
        if (start_i) begin
          value_d  = '0;
          status_d = STATUS_OK;
          state_d  = S_RESP;
          case (req_i.mode)
            MODE_LOAD_ONE: begin
              if (count1_q >= CNT_W'(MAX_EVENTS)) begin
                status_d = STATUS_FULL;
              end else begin
                r1_we    = 1'b1;
                count1_d = count1_q + CNT_W'(1);
                if (lab_in > k1_q) k1_d = lab_in;
              end
            end
            MODE_LOAD_TWO: begin
              if (count2_q >= CNT_W'(MAX_EVENTS)) begin
                status_d = STATUS_FULL;
              end else begin
                r2_we    = 1'b1;
                count2_d = count2_q + CNT_W'(1);
                if (lab_in > k2_q) k2_d = lab_in;
              end
            end
            MODE_COMPUTE: begin
              matk1_d    = k1_q;
              matk2_d    = k2_q;
              computed_d = 1'b1;
              total_d    = '0;
              clr_d      = '0;
              state_d    = S_CLEAR;
            end
            default: begin
              if (req_i.cell_row > matk1_q || req_i.cell_col > matk2_q) begin
                status_d = STATUS_RANGE;
              end else if (computed_q) begin
                state_d = S_CELL;
              end
            end
          endcase
        end
      end

      S_CELL: begin
        value_d = cm_rd;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (rsp_ack_i) state_d = S_IDLE;
      end

      // Zero flags and tables, one entry of each per cycle
      S_CLEAR: begin
        c1_we = 1'b1;
        c2_we = 1'b1;
        pc_we = 1'b1;
        cm_we = 1'b1;
        clr_d = clr_q + SWEEP_AW'(1);
        if (clr_q == SWEEP_AW'(SWEEP_N - 1)) begin
          pass_d  = 1'b0;
          i_d     = '0;
          j_d     = '0;
          state_d = S_I_RD;
        end
      end

      // Walk list one
      S_I_RD: begin
        if (i_q == count1_q) begin
          i_d = '0;
          j_d = '0;
          if (!pass_q) begin
            pass_d = 1'b1;
          end else begin
            state_d = S_U1_RD;
          end
        end else begin
          state_d = S_I_CHK;
        end
      end

      S_I_CHK: begin
        if (r1_lab == '0) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_I_RD;
        end else begin
          t_d     = r1_time;
          l1_d    = r1_lab;
          found_d = 1'b0;
          best_d  = '0;
          state_d = S_J_RD;
        end
      end

      // Advance the forward pointer over list two
      S_J_RD: begin
        if (j_q == count2_q) begin
          k_d     = j_q;
          state_d = S_K_RD;
        end else begin
          state_d = S_J_CHK;
        end
      end

      S_J_CHK: begin
        if (j_before) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_J_RD;
        end else begin
          k_d     = j_q;
          state_d = S_K_RD;
        end
      end

      // Scan the window
      S_K_RD: begin
        state_d = (k_q == count2_q) ? S_END_I : S_K_CHK;
      end

      S_K_CHK: begin
        if (!k_inside) begin
          state_d = S_END_I;
        end else if (r2_lab == '0 || c2_rd) begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_K_RD;
        end else begin
          idx_d   = cell_idx(l1_q, r2_lab);
          l2_d    = r2_lab;
          state_d = S_PC_WR;
        end
      end

      S_PC_WR: begin
        pc_we = 1'b1;
        pc_wa = idx_q;
        pc_wd = pc_inc;
        if (pass_q && pc_inc > best_q) begin
          best_d  = pc_inc;
          bj_d    = k_q[LIST_AW-1:0];
          bl2_d   = l2_q;
          found_d = 1'b1;
        end
        k_d     = k_q + CNT_W'(1);
        state_d = S_K_RD;
      end

      // Commit a match
      S_END_I: begin
        if (found_q) begin
          idx_d   = cell_idx(l1_q - LABEL_W'(1), bl2_q - LABEL_W'(1));
          cm_ra   = idx_d;
          c1_we   = 1'b1;
          c1_wa   = i_q[LIST_AW-1:0];
          c1_wd   = 1'b1;
          c2_we   = 1'b1;
          c2_wa   = bj_q;
          c2_wd   = 1'b1;
          total_d = total_q + VALUE_W'(1);
          state_d = S_M_WR;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_I_RD;
        end
      end

      S_M_WR: begin
        cm_we   = 1'b1;
        cm_wa   = idx_q;
        cm_wd   = cm_inc;
        i_d     = i_q + CNT_W'(1);
        state_d = S_I_RD;
      end

      // Unmatched list-one events
      S_U1_RD: begin
        if (i_q == count1_q) begin
          scan_two_d = 1'b1;
          j_d        = '0;
          state_d    = S_U2_RD;
        end else begin
          scan_two_d = 1'b0;
          state_d    = S_U1_CHK;
        end
      end

      S_U1_CHK: begin
        if (r1_lab != '0 && !c1_rd) begin
          idx_d   = cell_idx(r1_lab - LABEL_W'(1), matk2_q);
          cm_ra   = idx_d;
          total_d = total_q + VALUE_W'(1);
          state_d = S_U_WR;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_U1_RD;
        end
      end

      // Unmatched list-two events
      S_U2_RD: begin
        if (j_q == count2_q) begin
          value_d = total_q;
          state_d = S_RESP;
        end else begin
          state_d = S_U2_CHK;
        end
      end

      S_U2_CHK: begin
        if (r2_lab != '0 && !c2_rd) begin
          idx_d   = cell_idx(matk1_q, r2_lab - LABEL_W'(1));
          cm_ra   = idx_d;
          total_d = total_q + VALUE_W'(1);
          state_d = S_U_WR;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_U2_RD;
        end
      end

      S_U_WR: begin
        cm_we = 1'b1;
        cm_wa = idx_q;
        cm_wd = cm_inc;
        if (scan_two_q) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_U2_RD;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_U1_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count1_q   <= '0;
      count2_q   <= '0;
      k1_q       <= '0;
      k2_q       <= '0;
      matk1_q    <= '0;
      matk2_q    <= '0;
      computed_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count1_q   <= count1_d;
      count2_q   <= count2_d;
      k1_q       <= k1_d;
      k2_q       <= k2_d;
      matk1_q    <= matk1_d;
      matk2_q    <= matk2_d;
      computed_q <= computed_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    pass_q     <= pass_d;
    scan_two_q <= scan_two_d;
    found_q    <= found_d;
    clr_q      <= clr_d;
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    t_q        <= t_d;
    l1_q       <= l1_d;
    l2_q       <= l2_d;
    bl2_q      <= bl2_d;
    best_q     <= best_d;
    total_q    <= total_d;
    value_q    <= value_d;
    bj_q       <= bj_d;
    idx_q      <= idx_d;
    status_q   <= status_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = '{value: value_q, max_label_one: k1_q, max_label_two: k2_q,
                         status: status_q};

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count1_q <= CNT_W'(MAX_EVENTS) && count2_q <= CNT_W'(MAX_EVENTS))
    else $error("event count beyond list depth");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_K_RD) |-> (k_q >= j_q && k_q <= count2_q))
    else $error("window scan pointer out of order");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && status_q != STATUS_OK) |-> (value_q == '0))
    else $error("error response carries a value");

  a_list_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_RESP) |=> $stable(count1_q))
    else $error("list one changed during compute");

endmodule

// ===== design/windowed_event_label_matcher_unit.sv =====
// Windowed event label matcher: loads two sorted event lists, matches them
// within a time window and serves a confusion matrix. One beat is handled at a
// time. A compute first sweeps the flag, pair-count and confusion tables, one
// entry a cycle, then walks list one twice, for each labelled event stepping a
// pointer over list two and counting the labelled unconsumed events inside the
// window, and commits at most one match per event in the second pass. The
// unmatched scans then walk list one and list two. All tables sit in synchronous
// memories with one read and one write port. A finished result waits in the
// output register while the next beat is taken.
// Depends on welm_pkg, welm_core, welm_ram.
module windowed_event_label_matcher_unit import welm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i,    // match_window
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,   // event_time, event_label, cell_row, cell_col
  input  logic [MODE_W-1:0] s_axis_tuser,  // mode
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata    // value, max_label_one, max_label_two, status
);

  logic [WIN_W-1:0] win_q;
  logic             core_ready, rsp_valid, rsp_ack, start;
  req_t             req;
  rsp_t             rsp, out_q;
  logic             out_valid_q;

  // Window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Request decode
  assign s_axis_tready   = core_ready;
  assign start           = s_axis_tvalid & core_ready;
  assign req.mode        = mode_e'(s_axis_tuser);
  assign req.event_time  = s_axis_tdata[TIME_W-1:0];
  assign req.event_label = s_axis_tdata[TIME_W +: LABEL_W];
  assign req.cell_row    = s_axis_tdata[TIME_W + LABEL_W +: LABEL_W];
  assign req.cell_col    = s_axis_tdata[TIME_W + 2*LABEL_W +: LABEL_W];

  welm_core u_core (
    .clk_i, .rst_ni, .win_i(win_q), .start_i(start), .req_i(req),
    .ready_o(core_ready), .rsp_valid_o(rsp_valid), .rsp_ack_i(rsp_ack), .rsp_o(rsp));

  // Output register
  assign rsp_ack = rsp_valid & (~out_valid_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ack) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ack) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.status, out_q.max_label_two, out_q.max_label_one,
                          out_q.value};

endmodule

// ===== sim/tb_windowed_event_label_matcher_unit.sv =====
// Self-checking testbench for windowed_event_label_matcher_unit: drives loads, computes and
// cell reads over the stream ports and checks every result against a behavioral predictor.
// Depends on welm_pkg and the windowed_event_label_matcher_unit RTL.
module tb_windowed_event_label_matcher_unit;
  import welm_pkg::*;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] ev_time;
    logic [5:0]  label;
    logic [5:0]  row;
    logic [5:0]  col;
  } beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  top_one;
    logic [5:0]  top_two;
    status_e     status;
  } result_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [55:0] s_axis_tdata;   // event_time, event_label, cell_row, cell_col
  logic [1:0]  s_axis_tuser;   // mode
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;   // value, max_label_one, max_label_two, status

  windowed_event_label_matcher_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Predictor state
  logic [31:0] tim_one [MAX_EVENTS];
  logic [5:0]  lab_one [MAX_EVENTS];
  logic [31:0] tim_two [MAX_EVENTS];
  logic [5:0]  lab_two [MAX_EVENTS];
  bit          used_one [MAX_EVENTS];
  bit          used_two [MAX_EVENTS];
  logic [31:0] pairs [SIDE*SIDE];
  logic [31:0] cells [SIDE*SIDE];
  int          n_one, n_two;
  logic [5:0]  top_one, top_two, lat_k1, lat_k2;
  logic [15:0] win;

  beat_t   pending[$];
  result_t expected[$];
  int      errors, beats_in, results_out;
  int      n_computes, n_reads, n_drops, n_range;

  // Generator shadow
  int          gc1, gc2, spacing;
  logic [5:0]  gk1, gk2, lk1, lk2;
  logic [31:0] last1, last2;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic longint eff_two(int k);
    return used_two[k] ? -64'sd1 : longint'(tim_two[k]);
  endfunction

  // Two-pass windowed match, then confusion matrix of matched/unmatched events
  function automatic logic [31:0] run_match();
    longint      w, t;
    int          i, j, k, pass, bj, l1, idx;
    logic [31:0] best, total;
    bit          found;
    w = longint'(win);
    total = 0;
    foreach (used_one[x]) used_one[x] = 0;
    foreach (used_two[x]) used_two[x] = 0;
    foreach (pairs[x]) pairs[x] = 0;
    foreach (cells[x]) cells[x] = 0;
    lat_k1 = top_one;
    lat_k2 = top_two;
    for (pass = 0; pass < 2; pass++) begin
      j = 0;
      for (i = 0; i < n_one; i++) begin
        l1 = lab_one[i];
        if (l1 == 0 || used_one[i]) continue;
        t = longint'(tim_one[i]);
        best = 0; found = 0; bj = 0;
        while (j < n_two && eff_two(j) < t - w) j++;
        for (k = j; k < n_two && eff_two(k) <= t + w; k++) begin
          if (lab_two[k] == 0 || used_two[k]) continue;
          idx = l1 * SIDE + lab_two[k];
          pairs[idx] = bump(pairs[idx]);
          if (pass == 1 && pairs[idx] > best) begin
            best = pairs[idx]; bj = k; found = 1;
          end
        end
        if (found) begin
          idx = (l1 - 1) * SIDE + (lab_two[bj] - 1);
          cells[idx] = bump(cells[idx]);
          used_one[i] = 1;
          used_two[bj] = 1;
          total++;
        end
      end
    end
    for (i = 0; i < n_one; i++)
      if (lab_one[i] != 0 && !used_one[i]) begin
        idx = (lab_one[i] - 1) * SIDE + lat_k2;
        cells[idx] = bump(cells[idx]);
        total++;
      end
    for (i = 0; i < n_two; i++)
      if (lab_two[i] != 0 && !used_two[i]) begin
        idx = lat_k1 * SIDE + (lab_two[i] - 1);
        cells[idx] = bump(cells[idx]);
        total++;
      end
    return total;
  endfunction

  // Expected result of one accepted beat
  task automatic predict_beat(beat_t b);
    result_t r;
    r = '0;
    r.status = STATUS_OK;
    case (b.mode)
      MODE_LOAD_ONE: begin
        if (n_one >= MAX_EVENTS) begin
          r.status = STATUS_FULL; n_drops++;
        end else begin
          tim_one[n_one] = b.ev_time; lab_one[n_one] = b.label; n_one++;
          if (b.label > top_one) top_one = b.label;
        end
      end
      MODE_LOAD_TWO: begin
        if (n_two >= MAX_EVENTS) begin
          r.status = STATUS_FULL; n_drops++;
        end else begin
          tim_two[n_two] = b.ev_time; lab_two[n_two] = b.label; n_two++;
          if (b.label > top_two) top_two = b.label;
        end
      end
      MODE_COMPUTE: begin
        r.value = run_match();
        n_computes++;
      end
      default: begin
        n_reads++;
        if (b.row > lat_k1 || b.col > lat_k2) begin
          r.status = STATUS_RANGE; n_range++;
        end else begin
          r.value = cells[b.row * SIDE + b.col];
        end
      end
    endcase
    r.top_one = top_one;
    r.top_two = top_two;
    expected.push_back(r);
  endtask

  // Clock and reset
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Sample DUT outputs away from the active edge
  logic        s_rdy_q, m_vld_q;
  logic [47:0] m_data_q;
  always @(negedge clk_i) begin
    s_rdy_q  = s_axis_tready;
    m_vld_q  = m_axis_tvalid;
    m_data_q = m_axis_tdata;
  end

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t b;
    bit    gap;
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_rdy_q) begin
        b.mode    = mode_e'(s_axis_tuser);
        b.ev_time = s_axis_tdata[31:0];
        b.label   = s_axis_tdata[37:32];
        b.row     = s_axis_tdata[43:38];
        b.col     = s_axis_tdata[49:44];
        predict_beat(b);
        beats_in++;
      end
      if (!s_axis_tvalid || s_rdy_q) begin
        gap = !(beats_in >= 400 && beats_in < 600) && ($urandom_range(0, 99) < 36);
        if (pending.size() > 0 && !gap) begin
          b = pending.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tuser  <= b.mode;
          s_axis_tdata  <= {6'b0, b.col, b.row, b.label, b.ev_time};
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // Result monitor and checker
  int hold_left;
  bit held;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 0;
      hold_left = 0;
      held = 0;
    end else begin
      if (m_vld_q && m_axis_tready) begin
        got.value   = m_data_q[31:0];
        got.top_one = m_data_q[37:32];
        got.top_two = m_data_q[43:38];
        got.status  = status_e'(m_data_q[45:44]);
        results_out++;
        if (expected.size() == 0) begin
          $error("result beat with nothing expected: %h", m_data_q);
          errors++;
        end else begin
          want = expected.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value); errors++;
          end
          if (got.top_one !== want.top_one) begin
            $error("max_label_one: expected %0d, got %0d", want.top_one, got.top_one);
            errors++;
          end
          if (got.top_two !== want.top_two) begin
            $error("max_label_two: expected %0d, got %0d", want.top_two, got.top_two);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); errors++;
          end
        end
        // long back-pressure stretch once, while the sender keeps going
        if (results_out == 250 && !held) begin
          held = 1;
          hold_left = 400;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= (beats_in >= 400 && beats_in < 600) || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Stimulus helpers
  task automatic push_beat(mode_e m, logic [31:0] t, logic [5:0] lab,
                           logic [5:0] row, logic [5:0] col);
    beat_t b;
    b.mode = m; b.ev_time = t; b.label = lab; b.row = row; b.col = col;
    if (m == MODE_LOAD_ONE) begin
      gc1++; if (lab > gk1) gk1 = lab;
    end else if (m == MODE_LOAD_TWO) begin
      gc2++; if (lab > gk2) gk2 = lab;
    end else if (m == MODE_COMPUTE) begin
      lk1 = gk1; lk2 = gk2;
    end
    pending.push_back(b);
  endtask

  function automatic logic [5:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 6'd0;
    if (r < 97) return 6'($urandom_range(1, 6));
    return 6'($urandom_range(1, 63));
  endfunction

  task automatic push_load(bit noisy);
    bit          second;
    logic [31:0] t;
    second = 1'($urandom_range(0, 1));
    if (noisy) t = $urandom;
    else begin
      t = second ? last2 : last1;
      if ($urandom_range(0, 99) >= 15) t = t + $urandom_range(0, spacing);
      if (second) last2 = t; else last1 = t;
    end
    push_beat(second ? MODE_LOAD_TWO : MODE_LOAD_ONE, t, noisy ? 6'($urandom) : pick_label(),
              6'($urandom), 6'($urandom));
  endtask

  // Sorted load into list one only
  task automatic push_load_one();
    logic [31:0] t;
    t = last1;
    if ($urandom_range(0, 99) >= 15) t = t + $urandom_range(0, spacing);
    last1 = t;
    push_beat(MODE_LOAD_ONE, t, pick_label(), 6'($urandom), 6'($urandom));
  endtask

  task automatic push_reads(int n);
    logic [5:0] r, c;
    repeat (n) begin
      if ($urandom_range(0, 99) < 20) begin
        r = 6'($urandom); c = 6'($urandom);
      end else begin
        r = 6'($urandom_range(0, lk1)); c = 6'($urandom_range(0, lk2));
      end
      push_beat(MODE_READ, $urandom, 6'($urandom), r, c);
    end
  endtask

  task automatic push_compute();
    push_beat(MODE_COMPUTE, $urandom, 6'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // Sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending.size() > 0 || s_axis_tvalid || expected.size() > 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_window(logic [15:0] v);
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    win = v;
    @(posedge clk_i);
    cfg_we_i    <= 0;
  endtask

  // Stimulus sequence
  initial begin
    int r;
    cfg_we_i = 0; cfg_wdata_i = '0; win = '0;
    n_one = 0; n_two = 0; top_one = 0; top_two = 0; lat_k1 = 0; lat_k2 = 0;
    errors = 0; beats_in = 0; results_out = 0;
    n_computes = 0; n_reads = 0; n_drops = 0; n_range = 0;
    gc1 = 0; gc2 = 0; gk1 = 0; gk2 = 0; lk1 = 0; lk2 = 0;
    foreach (used_one[x]) used_one[x] = 0;
    foreach (used_two[x]) used_two[x] = 0;
    foreach (pairs[x]) pairs[x] = 0;
    foreach (cells[x]) cells[x] = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    write_window(16'd3);

    // Directed: empty compute, range reads, label extremes, unlabelled events,
    // unmatched events on both sides, loads at the time extremes
    push_compute();
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd0, 6'd0);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd1, 6'd0);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd0, 6'd63);
    push_beat(MODE_LOAD_ONE, 32'd0, 6'd2, 6'd0, 6'd0);
    push_beat(MODE_LOAD_TWO, 32'd2, 6'd0, 6'd0, 6'd0);
    push_beat(MODE_LOAD_TWO, 32'd3, 6'd5, 6'd0, 6'd0);
    push_beat(MODE_LOAD_ONE, 32'd3, 6'd63, 6'd0, 6'd0);
    push_beat(MODE_LOAD_TWO, 32'd6, 6'd63, 6'd0, 6'd0);
    push_beat(MODE_LOAD_ONE, 32'd10, 6'd0, 6'd0, 6'd0);
    push_beat(MODE_LOAD_TWO, 32'd13, 6'd2, 6'd0, 6'd0);
    push_beat(MODE_LOAD_ONE, 32'hFFFF_FFFF, 6'd1, 6'd0, 6'd0);
    push_beat(MODE_LOAD_TWO, 32'hFFFF_FFFE, 6'd1, 6'd0, 6'd0);
    push_compute();
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd1, 6'd4);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd62, 6'd62);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd63, 6'd0);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd1, 6'd63);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd63, 6'd63);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd0, 6'd1);
    push_beat(MODE_READ, 32'd0, 6'd0, 6'd62, 6'd4);
    last1 = 32'd100; last2 = 32'd100;

    // Random phases: mostly sorted loads with random content, compute, cell reads
    while (beats_in < 330) begin
      wait_idle();
      r = $urandom_range(0, 99);
      write_window(r < 10 ? 16'd0 : (r < 16 ? 16'hFFFF : 16'($urandom_range(1, 3000))));
      spacing = $urandom_range(0, 3000);
      repeat ($urandom_range(2, 16)) push_load($urandom_range(0, 99) < 5);
      push_compute();
      push_reads($urandom_range(3, 12));
    end

    // Fill list one past capacity, then compute at both window extremes
    wait_idle();
    write_window(16'($urandom_range(1, 3000)));
    spacing = 2000;
    while (gc1 < MAX_EVENTS + 3) push_load_one();
    push_compute();
    push_reads(12);
    wait_idle();
    write_window(16'hFFFF);
    push_compute();
    push_reads(12);
    wait_idle();
    write_window(16'd0);
    push_compute();
    push_reads(12);

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d input beats, %0d computes, %0d cell reads (%0d outside matrix),",
             beats_in, n_computes, n_reads, n_range);
    $display("and %0d loads dropped on full lists; %0d results checked.",
             n_drops, results_out);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
design/welm_pkg.sv
design/welm_ram.sv
design/welm_core.sv
design/windowed_event_label_matcher_unit.sv
sim/tb_windowed_event_label_matcher_unit.sv
